[sv/adb_mouse_report_merger_assert.svh]
// Assertion macros for the mouse report merger checker.
// No dependencies; include by bare file name.
`ifndef ADB_MOUSE_REPORT_MERGER_ASSERT_SVH
`define ADB_MOUSE_REPORT_MERGER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ADBMRM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("adbmrm assertion failed");

// Next-cycle implication, disabled during reset.
`define ADBMRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("adbmrm assertion failed");

`endif

[sv/adbmrm_pkg.sv]
// Shared types, constants and helpers for the mouse report merger.
// No dependencies.
package adbmrm_pkg;

    localparam int DEF_NUM_DEVICES = 16;
    localparam int DEF_ACC_WIDTH   = 16;

    localparam logic [2:0] BTN_ALL_UP  = 3'b111;
    localparam logic [7:0] REPORT_MARK = 8'h80;
    localparam int         OPND_W      = 9;

    typedef enum logic [1:0] {
        STAT_ABSORBED = 2'd0,
        STAT_REPORT   = 2'd1,
        STAT_NO_DATA  = 2'd2
    } status_t;

    // Sign-extend a 7-bit motion field to the operand width.
    function automatic logic signed [OPND_W-1:0] sext7(input logic [7:0] b);
        sext7 = {{(OPND_W-7){b[6]}}, b[6:0]};
    endfunction

endpackage

[sv/adb_mouse_report_merger.sv]
// Mouse report merger: per-device button table, merged buttons,
// saturating motion accumulators and a clamped report port.
// Depends on adbmrm_pkg.
//
// Usage: the s_ channel takes one item per handshake. cmd = 0 carries a
// mouse packet; cmd = 1 asks for one report. Every item yields exactly one
// result item on the m_ channel.
// A packet walks the button table one entry per cycle, updating the entry
// of its device and ANDing all entries, then runs the X and Y sums through
// the shared saturating adder, X first. A read runs the clamp/subtract
// for X and then Y through the same adder. A read with no data ready
// answers in the cycle after acceptance.
// One item is in flight at a time; s_ready is high only while idle, so a
// new item is taken only after the result handshake.
// A stalled receiver holds the result registers and keeps s_ready low.
// Reset: all buttons up, accumulators zero, ready flag clear, idle.
module adb_mouse_report_merger #(
    parameter int NUM_DEVICES = adbmrm_pkg::DEF_NUM_DEVICES,
    parameter int ACC_WIDTH   = adbmrm_pkg::DEF_ACC_WIDTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_cmd,
    input  logic [7:0]        s_header_byte,
    input  logic [7:0]        s_motion_byte_a,
    input  logic [7:0]        s_motion_byte_b,
    input  logic [7:0]        s_extra_byte,
    input  logic              s_extended_format,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic [7:0]        m_report_buttons,
    output logic signed [7:0] m_report_dx,
    output logic signed [7:0] m_report_dy,
    output logic              m_data_ready
);
    import adbmrm_pkg::*;

    localparam int IDX_W = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DEVICES - 1);
    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SWEEP = 7'b0000010,
        ST_ACCX  = 7'b0000100,
        ST_ACCY  = 7'b0001000,
        ST_RDX   = 7'b0010000,
        ST_RDY   = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]             dev_btn_reg [NUM_DEVICES];
    logic [2:0]             merged_reg;
    logic signed [ACC_WIDTH-1:0] accx_reg, accy_reg;
    logic                   ready_flag_reg;
    logic [IDX_W-1:0]       cnt_reg;
    logic [IDX_W-1:0]       id_reg;
    logic [7:0]             byte_a_reg, byte_b_reg, extra_reg;
    logic                   ext_reg;
    status_t                status_reg;
    logic [7:0]             rep_btn_reg;
    logic signed [7:0]      rep_dx_reg, rep_dy_reg;

    // Shared saturating adder.
    logic signed [ACC_WIDTH-1:0] unit_a;
    logic signed [OPND_W-1:0]    unit_b;
    logic signed [ACC_WIDTH:0]   unit_sum;
    logic signed [ACC_WIDTH-1:0] unit_out;

    logic signed [ACC_WIDTH-1:0] clamp_src;
    logic signed [7:0]           clamp_val;
    logic [ACC_WIDTH-8:0]        clamp_hi;
    logic [2:0]                  entry_new;
    logic [IDX_W-1:0]            id_in;
    logic                        accept;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_DONE);

    assign m_status         = status_reg;
    assign m_report_buttons = rep_btn_reg;
    assign m_report_dx      = rep_dx_reg;
    assign m_report_dy      = rep_dy_reg;
    assign m_data_ready     = ready_flag_reg;

    // Saturate device ids past the table to its last entry.
    assign id_in = (32'(s_header_byte[7:4]) >= NUM_DEVICES) ? LAST_IDX
                                                              : s_header_byte[4 +: IDX_W];

    assign entry_new = {byte_a_reg[7], byte_b_reg[7],
                        ext_reg ? extra_reg[7] : dev_btn_reg[cnt_reg][0]};

    // Clamp the selected accumulator to a signed byte.
    assign clamp_src = (state_reg == ST_RDY) ? accy_reg : accx_reg;
    assign clamp_hi  = clamp_src[ACC_WIDTH-1:7];
    always_comb begin
        if ((&clamp_hi) || !(|clamp_hi)) begin
            clamp_val = clamp_src[7:0];
        end else if (clamp_src[ACC_WIDTH-1]) begin
            clamp_val = -8'sd128;
        end else begin
            clamp_val = 8'sd127;
        end
    end

    always_comb begin
        case (state_reg)
            ST_ACCX: begin
                unit_a = accx_reg;
                unit_b = sext7(byte_b_reg);
            end
            ST_ACCY: begin
                unit_a = accy_reg;
                unit_b = -sext7(byte_a_reg);
            end
            ST_RDX: begin
                unit_a = accx_reg;
                unit_b = -{clamp_val[7], clamp_val};
            end
            ST_RDY: begin
                unit_a = accy_reg;
                unit_b = -{clamp_val[7], clamp_val};
            end
            default: begin
                unit_a = accx_reg;
                unit_b = '0;
            end
        endcase
    end

    assign unit_sum = {unit_a[ACC_WIDTH-1], unit_a}
                    + {{(ACC_WIDTH+1-OPND_W){unit_b[OPND_W-1]}}, unit_b};
    assign unit_out = (unit_sum[ACC_WIDTH] == unit_sum[ACC_WIDTH-1])
                    ? unit_sum[ACC_WIDTH-1:0]
                    : (unit_sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!s_cmd) begin
                        state_next = ST_SWEEP;
                    end else if (ready_flag_reg) begin
                        state_next = ST_RDX;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SWEEP: begin
                if (cnt_reg == LAST_IDX) begin
                    state_next = ST_ACCX;
                end
            end
            ST_ACCX:  state_next = ST_ACCY;
            ST_ACCY:  state_next = ST_DONE;
            ST_RDX:   state_next = ST_RDY;
            ST_RDY:   state_next = ST_DONE;
            ST_DONE: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            merged_reg     <= BTN_ALL_UP;
            accx_reg       <= '0;
            accy_reg       <= '0;
            ready_flag_reg <= 1'b0;
            cnt_reg        <= '0;
            status_reg     <= STAT_ABSORBED;
            for (int i = 0; i < NUM_DEVICES; i++) begin
                dev_btn_reg[i] <= BTN_ALL_UP;
            end
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        cnt_reg <= '0;
                        if (!s_cmd) begin
                            merged_reg     <= BTN_ALL_UP;
                            ready_flag_reg <= 1'b1;
                            status_reg     <= STAT_ABSORBED;
                        end else if (ready_flag_reg) begin
                            status_reg <= STAT_REPORT;
                        end else begin
                            status_reg <= STAT_NO_DATA;
                        end
                    end
                end
                ST_SWEEP: begin
                    // Rewrite the addressed entry on the fly and fold it in.
                    if (cnt_reg == id_reg) begin
                        dev_btn_reg[cnt_reg] <= entry_new;
                        merged_reg <= merged_reg & entry_new;
                    end else begin
                        merged_reg <= merged_reg & dev_btn_reg[cnt_reg];
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
                ST_ACCX: accx_reg <= unit_out;
                ST_ACCY: accy_reg <= unit_out;
                ST_RDX:  accx_reg <= unit_out;
                ST_RDY: begin
                    accy_reg       <= unit_out;
                    ready_flag_reg <= !((accx_reg == '0) && (unit_out == '0));
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    id_reg      <= id_in;
                    byte_a_reg  <= s_motion_byte_a;
                    byte_b_reg  <= s_motion_byte_b;
                    extra_reg   <= s_extra_byte;
                    ext_reg     <= s_extended_format;
                    rep_btn_reg <= '0;
                    rep_dx_reg  <= '0;
                    rep_dy_reg  <= '0;
                end
            end
            ST_RDX: begin
                rep_dx_reg  <= clamp_val;
                rep_btn_reg <= REPORT_MARK | {5'b0, merged_reg};
            end
            ST_RDY:  rep_dy_reg <= clamp_val;
            default: begin
            end
        endcase
    end

endmodule

[sv/adbmrm_checker.sv]
// Port-level checker for the mouse report merger, bound to the top level.
// Depends on adbmrm_pkg and adb_mouse_report_merger_assert.svh.
`include "adb_mouse_report_merger_assert.svh"

module adbmrm_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [1:0]        m_status,
    input logic [7:0]        m_report_buttons,
    input logic signed [7:0] m_report_dx,
    input logic signed [7:0] m_report_dy,
    input logic              m_data_ready
);
    import adbmrm_pkg::*;

    // One item at a time: no new item right after one is taken.
    `ADBMRM_ASSERT_NEXT(a_single_item, aclk, aresetn, s_valid && s_ready, !s_ready)

    `ADBMRM_ASSERT_NOW(a_absorbed_sets_ready, aclk, aresetn,
        m_valid && (m_status == STAT_ABSORBED),
        m_data_ready && (m_report_buttons == '0) && (m_report_dx == '0))

    `ADBMRM_ASSERT_NOW(a_no_data_empty, aclk, aresetn,
        m_valid && (m_status == STAT_NO_DATA),
        !m_data_ready && (m_report_buttons == '0) && (m_report_dy == '0))

    `ADBMRM_ASSERT_NOW(a_report_format, aclk, aresetn,
        m_valid && (m_status == STAT_REPORT),
        m_report_buttons[7] && (m_report_buttons[6:3] == '0))

    `ADBMRM_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_status))

endmodule

bind adb_mouse_report_merger adbmrm_checker u_adbmrm_checker (.*);
